FILE: src/socu_pkg.sv
`timescale 1ns / 1ps
// Package for the slab order calculator: field widths, register indexes,
// sequencer state and fraction codes, remainder table write bundle.
// No dependencies.
package socu_pkg;

  localparam int SIZE_W      = 24;
  localparam int CNT_W       = 7;
  localparam int ORD_W       = 4;
  localparam int ORD_CNT_W   = 5;
  localparam int ORD_CAP     = 16;
  localparam int REM_ENTRIES = 16;
  localparam int REM_IDX_W   = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int MAX_ORD_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBJECTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER   = 1'd1;

  localparam logic [CNT_W-1:0]     MIN_OBJECTS_RST = 7'd64;
  localparam logic [MAX_ORD_W-1:0] MAX_ORDER_RST   = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DBL,
    ST_CNT,
    ST_FO,
    ST_TRY,
    ST_DONE
  } socu_state_t;

  typedef enum logic [1:0] {
    FR_16,
    FR_8,
    FR_4
  } socu_frac_t;

  typedef struct packed {
    logic                 en;
    logic [REM_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]    data;
  } socu_rt_wr_t;

endpackage

FILE: src/socu_alu.sv
`timescale 1ns / 1ps
// Shared compare-subtract unit of the slab order calculator.
// Depends on nothing; width set by the top level.
module socu_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  assign diff = a - b;
  assign ge   = (a >= b);

endmodule

FILE: src/socu_rem_table.sv
`timescale 1ns / 1ps
// Table of (page_bytes << order) mod size, one entry per order.
// Depends on socu_pkg.
module socu_rem_table (
  input  logic                          clk,
  input  socu_pkg::socu_rt_wr_t         wr,
  input  logic [socu_pkg::REM_IDX_W-1:0] rd_idx,
  output logic [socu_pkg::SIZE_W-1:0]    rd_data
);
  import socu_pkg::*;

  logic [SIZE_W-1:0] mem_r [REM_ENTRIES];
  logic [SIZE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
    rd_data_r <= mem_r[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/slab_order_calculator_unit.sv
`timescale 1ns / 1ps
// Slab order calculator: picks page order and object count for an object size.
// Depends on socu_pkg, socu_alu and socu_rem_table.
//
// Usage:
//   Input channel in_valid/in_stall carries in_obj_size. The block takes one
//   item while idle and raises in_stall until its result has been taken.
//   Result channel out_valid/out_stall carries out_order, out_objects_per_slab
//   and out_fail; the result is held in output registers while out_stall is high.
//   Configuration: cfg_we with cfg_index (0 = min_objects, 1 = max_order) and
//   cfg_wdata; write only while no item is in flight.
// Sequence from acceptance to out_valid:
//   remainder of page_bytes, one bit per cycle (PW = bits of PAGE_BYTES),
//   then the remainder table for the higher orders,
//   then per object count: the search for the first order, then per fraction
//   tried the orders checked; each rejected fraction restarts at the first order.
//   All of it runs through one compare-subtract unit; a zero size goes straight
//   to a failed result.
// A new item is taken only after the previous result has been taken.
// Reset: synchronous, active low; returns to idle, min_objects = 64, max_order = 10.
module slab_order_calculator_unit #(
  parameter int PAGE_BYTES        = 4096,
  parameter int PAGE_HEADER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [socu_pkg::SIZE_W-1:0]     in_obj_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [socu_pkg::ORD_W-1:0]      out_order,
  output logic [socu_pkg::CNT_W-1:0]      out_objects_per_slab,
  output logic                            out_fail,
  input  logic                            cfg_we,
  input  logic [socu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [socu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import socu_pkg::*;

  localparam int PW = $clog2(PAGE_BYTES + 1);
  localparam int DW = (PW + ORD_CAP > 32) ? PW + ORD_CAP : 32;
  localparam int IW = $clog2(PW);
  localparam logic [PW-1:0] PAGE_VEC = PW'(PAGE_BYTES);
  localparam logic [DW-1:0] PAGE_D   = DW'(PAGE_BYTES);
  localparam logic [DW-1:0] HDR_D    = DW'(PAGE_HEADER_BYTES);

  socu_state_t          state_r, state_nxt;
  socu_frac_t           frac_r, frac_nxt;
  logic [CNT_W-1:0]     min_obj_r;
  logic [MAX_ORD_W-1:0] max_ord_r;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [IW-1:0]        bit_r, bit_nxt;
  logic [REM_IDX_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ORD_CNT_W-1:0] ord_r, ord_nxt;
  logic [ORD_CNT_W-1:0] fo_r, fo_nxt;
  logic [DW-1:0]        cap_r, cap_nxt;
  logic [DW-1:0]        fcap_r, fcap_nxt;
  logic [DW-1:0]        nbytes_r, nbytes_nxt;
  logic [ORD_W-1:0]     res_order_r, res_order_nxt;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                 res_fail_r, res_fail_nxt;

  logic [DW-1:0]        alu_a, alu_b, alu_diff;
  logic                 alu_ge;
  socu_rt_wr_t          rt_wr;
  logic [SIZE_W-1:0]    rt_rd;
  logic [SIZE_W:0]      step_t;
  logic [SIZE_W-1:0]    step_rem;
  logic [SIZE_W+4:0]    rem_mul;
  logic [SIZE_W+CNT_W-1:0] prod;

  socu_alu #(.W(DW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  socu_rem_table u_rem_table (
    .clk     (clk),
    .wr      (rt_wr),
    .rd_idx  (ord_nxt[REM_IDX_W-1:0]),
    .rd_data (rt_rd)
  );

  assign prod     = (SIZE_W + CNT_W)'(size_r) * (SIZE_W + CNT_W)'(count_r);
  assign step_rem = alu_ge ? alu_diff[SIZE_W-1:0] : step_t[SIZE_W-1:0];

  always_comb begin
    case (frac_r)
      FR_16:   rem_mul = {1'b0, rt_rd, 4'b0} + (SIZE_W + 5)'(rt_rd);
      FR_8:    rem_mul = {2'b0, rt_rd, 3'b0} + (SIZE_W + 5)'(rt_rd);
      default: rem_mul = {3'b0, rt_rd, 2'b0} + (SIZE_W + 5)'(rt_rd);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    frac_nxt      = frac_r;
    size_nxt      = size_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    ord_nxt       = ord_r;
    fo_nxt        = fo_r;
    cap_nxt       = cap_r;
    fcap_nxt      = fcap_r;
    nbytes_nxt    = nbytes_r;
    res_order_nxt = res_order_r;
    res_cnt_nxt   = res_cnt_r;
    res_fail_nxt  = res_fail_r;
    alu_a         = '0;
    alu_b         = '0;
    rt_wr         = '0;
    step_t        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          size_nxt = in_obj_size;
          rem_nxt  = '0;
          bit_nxt  = IW'(PW - 1);
          if (in_obj_size == '0) begin
            res_order_nxt = '0;
            res_cnt_nxt   = '0;
            res_fail_nxt  = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        step_t  = {rem_r, PAGE_VEC[bit_r]};
        alu_a   = DW'(step_t);
        alu_b   = DW'(size_r);
        rem_nxt = step_rem;
        if (bit_r == '0) begin
          rt_wr.en   = 1'b1;
          rt_wr.idx  = '0;
          rt_wr.data = step_rem;
          k_nxt      = REM_IDX_W'(1);
          state_nxt  = ST_DBL;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_DBL: begin
        step_t     = {rem_r, 1'b0};
        alu_a      = DW'(step_t);
        alu_b      = DW'(size_r);
        rem_nxt    = step_rem;
        rt_wr.en   = 1'b1;
        rt_wr.idx  = k_r;
        rt_wr.data = step_rem;
        if (k_r == REM_IDX_W'(REM_ENTRIES - 1)) begin
          count_nxt = (min_obj_r > CNT_W'(1)) ? min_obj_r : CNT_W'(1);
          state_nxt = ST_CNT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_CNT: begin
        nbytes_nxt = DW'(prod) + HDR_D;
        ord_nxt    = '0;
        cap_nxt    = PAGE_D;
        frac_nxt   = FR_16;
        state_nxt  = ST_FO;
      end
      ST_FO: begin
        alu_a = cap_r;
        alu_b = nbytes_r;
        if (alu_ge || ord_r == ORD_CNT_W'(ORD_CAP)) begin
          fo_nxt    = ord_r;
          fcap_nxt  = cap_r;
          state_nxt = ST_TRY;
        end else begin
          cap_nxt = {cap_r[DW-2:0], 1'b0};
          ord_nxt = ord_r + 1'b1;
        end
      end
      ST_TRY: begin
        alu_a = cap_r;
        alu_b = DW'(rem_mul);
        if (ord_r >= ORD_CNT_W'(max_ord_r)) begin
          if (count_r == CNT_W'(1)) begin
            res_order_nxt = '0;
            res_cnt_nxt   = '0;
            res_fail_nxt  = 1'b1;
            state_nxt     = ST_DONE;
          end else if (frac_r != FR_4) begin
            frac_nxt = (frac_r == FR_16) ? FR_8 : FR_4;
            ord_nxt  = fo_r;
            cap_nxt  = fcap_r;
          end else begin
            count_nxt = (count_r > CNT_W'(2)) ? count_r - 1'b1 : CNT_W'(1);
            state_nxt = ST_CNT;
          end
        end else if (rt_rd == '0 || alu_ge) begin
          res_order_nxt = ord_r[ORD_W-1:0];
          res_cnt_nxt   = count_r;
          res_fail_nxt  = 1'b0;
          state_nxt     = ST_DONE;
        end else begin
          ord_nxt = ord_r + 1'b1;
          cap_nxt = {cap_r[DW-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      min_obj_r <= MIN_OBJECTS_RST;
      max_ord_r <= MAX_ORDER_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_OBJECTS: min_obj_r <= cfg_wdata[CNT_W-1:0];
          CFG_MAX_ORDER:   max_ord_r <= cfg_wdata[MAX_ORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    frac_r      <= frac_nxt;
    size_r      <= size_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    k_r         <= k_nxt;
    count_r     <= count_nxt;
    ord_r       <= ord_nxt;
    fo_r        <= fo_nxt;
    cap_r       <= cap_nxt;
    fcap_r      <= fcap_nxt;
    nbytes_r    <= nbytes_nxt;
    res_order_r <= res_order_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_fail_r  <= res_fail_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = (state_r == ST_DONE);
  assign out_order            = res_order_r;
  assign out_objects_per_slab = res_cnt_r;
  assign out_fail             = res_fail_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fail |-> out_order == '0 && out_objects_per_slab == '0)
    else $error("failed result carries nonzero fields");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fail |->
      out_objects_per_slab != '0 && out_order < max_ord_r)
    else $error("accepted result outside order bound");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !(out_valid && $past(out_valid)))
    else $error("block not busy after taking an item");

endmodule
